// ===== sv/mahu_pkg.sv =====
// Shared types, constants and arithmetic helpers of the attitude filter update block.
package mahu_pkg;

   localparam int QUAT_WIDTH   = 32;
   localparam int QF           = QUAT_WIDTH - 2;
   localparam int DATA_W       = 32;
   localparam int ACCEL_W      = 16;
   localparam int HSP_W        = 30;
   localparam int ACC_W        = 64;
   localparam int OPND_W       = 34;
   localparam int PROD_W       = 2 * OPND_W;
   localparam int ROOT_W       = 32;
   localparam int RAD_W        = 2 * ROOT_W;
   localparam int SQRT_CW      = $clog2(ROOT_W);
   localparam int ACCEL_SHIFT  = 46;
   localparam int RENORM_SHIFT = QF;
   localparam int DIV_NW       = (62 > 32 + QF) ? 62 : 32 + QF;
   localparam int DIV_RW       = DIV_NW + 1;
   localparam int DIV_CW       = $clog2(DIV_NW + 1);
   localparam int PC_W         = 6;
   localparam int TQ_W         = QUAT_WIDTH + 34;
   localparam int TQ_DN        = (QF >= 30) ? QF - 30 : 0;
   localparam int TQ_UP        = (QF < 30) ? 30 - QF : 0;

   localparam logic [HSP_W-1:0] HSP_RESET = HSP_W'(5368709);

   localparam logic [PC_W-1:0] PC_ACCEL_END = PC_W'(2);
   localparam logic [PC_W-1:0] PC_FB_START  = PC_W'(3);
   localparam logic [PC_W-1:0] PC_INT_START = PC_W'(16);
   localparam logic [PC_W-1:0] PC_LAST      = PC_W'(38);

   typedef struct packed {
      logic signed [DATA_W-1:0]  gyro_x;
      logic signed [DATA_W-1:0]  gyro_y;
      logic signed [DATA_W-1:0]  gyro_z;
      logic signed [ACCEL_W-1:0] accel_x;
      logic signed [ACCEL_W-1:0] accel_y;
      logic signed [ACCEL_W-1:0] accel_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] quat_w;
      logic signed [DATA_W-1:0] quat_x;
      logic signed [DATA_W-1:0] quat_y;
      logic signed [DATA_W-1:0] quat_z;
   } rsp_type;

   typedef enum logic [4:0] {
      OPD_Q0, OPD_Q1, OPD_Q2, OPD_Q3,
      OPD_A0, OPD_A1, OPD_A2,
      OPD_V0, OPD_V1, OPD_V2,
      OPD_G0, OPD_G1, OPD_G2,
      OPD_H0, OPD_H1, OPD_H2,
      OPD_N0, OPD_N1, OPD_N2, OPD_N3,
      OPD_ONE, OPD_HALF, OPD_HSP
   } opd_type;

   typedef enum logic [3:0] {
      DST_NONE,
      DST_V0, DST_V1, DST_V2,
      DST_G0, DST_G1, DST_G2,
      DST_H0, DST_H1, DST_H2,
      DST_N0, DST_N1, DST_N2, DST_N3
   } dst_type;

   typedef enum logic [1:0] {
      SHF_NONE, SHF_FLOOR2, SHF_RND24, SHF_RND30
   } shf_type;

   typedef struct packed {
      opd_type a;
      opd_type b;
      shf_type shift;
      logic    sub;
      logic    clr;
      dst_type dest;
   } uop_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_ACC, ST_SQRT, ST_DIV, ST_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic       acc_en;
      uop_type    uop;
      logic       renorm;
      logic       sqrt_start;
      logic       div_start;
      logic [1:0] start_idx;
      logic       div_write;
      logic [1:0] div_idx;
      logic       zero_state;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic acc_zero;
      logic sqrt_busy;
      logic root_zero;
      logic div_busy;
   } sts_type;

   function automatic uop_type mk(opd_type a, opd_type b, shf_type sh, logic sub, logic clr,
                                  dst_type dst);
      uop_type u;
      u.a     = a;
      u.b     = b;
      u.shift = sh;
      u.sub   = sub;
      u.clr   = clr;
      u.dest  = dst;
      return u;
   endfunction

   function automatic uop_type mahu_uop(logic [PC_W-1:0] pc);
      uop_type u;
      case (pc)
         6'd0:    u = mk(OPD_A0, OPD_A0, SHF_NONE, 1'b0, 1'b1, DST_NONE);
         6'd1:    u = mk(OPD_A1, OPD_A1, SHF_NONE, 1'b0, 1'b0, DST_NONE);
         6'd2:    u = mk(OPD_A2, OPD_A2, SHF_NONE, 1'b0, 1'b0, DST_NONE);
         6'd3:    u = mk(OPD_Q1, OPD_Q3, SHF_RND30, 1'b0, 1'b1, DST_NONE);
         6'd4:    u = mk(OPD_Q0, OPD_Q2, SHF_RND30, 1'b1, 1'b0, DST_V0);
         6'd5:    u = mk(OPD_Q0, OPD_Q1, SHF_RND30, 1'b0, 1'b1, DST_NONE);
         6'd6:    u = mk(OPD_Q2, OPD_Q3, SHF_RND30, 1'b0, 1'b0, DST_V1);
         6'd7:    u = mk(OPD_Q0, OPD_Q0, SHF_RND30, 1'b0, 1'b1, DST_NONE);
         6'd8:    u = mk(OPD_Q3, OPD_Q3, SHF_RND30, 1'b0, 1'b0, DST_NONE);
         6'd9:    u = mk(OPD_ONE, OPD_HALF, SHF_RND30, 1'b1, 1'b0, DST_V2);
         6'd10:   u = mk(OPD_A1, OPD_V2, SHF_RND30, 1'b0, 1'b1, DST_NONE);
         6'd11:   u = mk(OPD_A2, OPD_V1, SHF_RND30, 1'b1, 1'b0, DST_G0);
         6'd12:   u = mk(OPD_A2, OPD_V0, SHF_RND30, 1'b0, 1'b1, DST_NONE);
         6'd13:   u = mk(OPD_A0, OPD_V2, SHF_RND30, 1'b1, 1'b0, DST_G1);
         6'd14:   u = mk(OPD_A0, OPD_V1, SHF_RND30, 1'b0, 1'b1, DST_NONE);
         6'd15:   u = mk(OPD_A1, OPD_V0, SHF_RND30, 1'b1, 1'b0, DST_G2);
         6'd16:   u = mk(OPD_G0, OPD_HSP, SHF_RND24, 1'b0, 1'b1, DST_H0);
         6'd17:   u = mk(OPD_G1, OPD_HSP, SHF_RND24, 1'b0, 1'b1, DST_H1);
         6'd18:   u = mk(OPD_G2, OPD_HSP, SHF_RND24, 1'b0, 1'b1, DST_H2);
         6'd19:   u = mk(OPD_Q0, OPD_ONE, SHF_RND30, 1'b0, 1'b1, DST_NONE);
         6'd20:   u = mk(OPD_Q1, OPD_H0, SHF_RND30, 1'b1, 1'b0, DST_NONE);
         6'd21:   u = mk(OPD_Q2, OPD_H1, SHF_RND30, 1'b1, 1'b0, DST_NONE);
         6'd22:   u = mk(OPD_Q3, OPD_H2, SHF_RND30, 1'b1, 1'b0, DST_N0);
         6'd23:   u = mk(OPD_Q1, OPD_ONE, SHF_RND30, 1'b0, 1'b1, DST_NONE);
         6'd24:   u = mk(OPD_Q0, OPD_H0, SHF_RND30, 1'b0, 1'b0, DST_NONE);
         6'd25:   u = mk(OPD_Q2, OPD_H2, SHF_RND30, 1'b0, 1'b0, DST_NONE);
         6'd26:   u = mk(OPD_Q3, OPD_H1, SHF_RND30, 1'b1, 1'b0, DST_N1);
         6'd27:   u = mk(OPD_Q2, OPD_ONE, SHF_RND30, 1'b0, 1'b1, DST_NONE);
         6'd28:   u = mk(OPD_Q0, OPD_H1, SHF_RND30, 1'b0, 1'b0, DST_NONE);
         6'd29:   u = mk(OPD_Q1, OPD_H2, SHF_RND30, 1'b1, 1'b0, DST_NONE);
         6'd30:   u = mk(OPD_Q3, OPD_H0, SHF_RND30, 1'b0, 1'b0, DST_N2);
         6'd31:   u = mk(OPD_Q3, OPD_ONE, SHF_RND30, 1'b0, 1'b1, DST_NONE);
         6'd32:   u = mk(OPD_Q0, OPD_H2, SHF_RND30, 1'b0, 1'b0, DST_NONE);
         6'd33:   u = mk(OPD_Q1, OPD_H1, SHF_RND30, 1'b0, 1'b0, DST_NONE);
         6'd34:   u = mk(OPD_Q2, OPD_H0, SHF_RND30, 1'b1, 1'b0, DST_N3);
         6'd35:   u = mk(OPD_N0, OPD_N0, SHF_FLOOR2, 1'b0, 1'b1, DST_NONE);
         6'd36:   u = mk(OPD_N1, OPD_N1, SHF_FLOOR2, 1'b0, 1'b0, DST_NONE);
         6'd37:   u = mk(OPD_N2, OPD_N2, SHF_FLOOR2, 1'b0, 1'b0, DST_NONE);
         6'd38:   u = mk(OPD_N3, OPD_N3, SHF_FLOOR2, 1'b0, 1'b0, DST_NONE);
         default: u = mk(OPD_ONE, OPD_ONE, SHF_NONE, 1'b0, 1'b1, DST_NONE);
      endcase
      return u;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_acc32(logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
      lo = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
      if (x > hi) return hi[DATA_W-1:0];
      if (x < lo) return lo[DATA_W-1:0];
      return x[DATA_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_div32(logic signed [DIV_RW-1:0] x);
      logic signed [DIV_RW-1:0] hi;
      logic signed [DIV_RW-1:0] lo;
      hi = {{(DIV_RW-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
      lo = {{(DIV_RW-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
      if (x > hi) return hi[DATA_W-1:0];
      if (x < lo) return lo[DATA_W-1:0];
      return x[DATA_W-1:0];
   endfunction

   function automatic logic signed [QUAT_WIDTH-1:0] sat_divq(logic signed [DIV_RW-1:0] x);
      logic signed [DIV_RW-1:0] hi;
      logic signed [DIV_RW-1:0] lo;
      hi = {{(DIV_RW-QUAT_WIDTH+1){1'b0}}, {(QUAT_WIDTH-1){1'b1}}};
      lo = {{(DIV_RW-QUAT_WIDTH+1){1'b1}}, {(QUAT_WIDTH-1){1'b0}}};
      if (x > hi) return hi[QUAT_WIDTH-1:0];
      if (x < lo) return lo[QUAT_WIDTH-1:0];
      return x[QUAT_WIDTH-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] to_q30(logic signed [QUAT_WIDTH-1:0] v);
      logic signed [TQ_W-1:0] w;
      logic signed [TQ_W-1:0] rnd;
      logic signed [TQ_W-1:0] hi;
      logic signed [TQ_W-1:0] lo;
      rnd = (TQ_DN > 0) ? (TQ_W'(1) <<< (TQ_DN > 0 ? TQ_DN - 1 : 0)) : '0;
      hi  = {{(TQ_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
      lo  = {{(TQ_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
      w   = ((TQ_W'(v) + rnd) >>> TQ_DN) <<< TQ_UP;
      if (w > hi) return hi[DATA_W-1:0];
      if (w < lo) return lo[DATA_W-1:0];
      return w[DATA_W-1:0];
   endfunction

endpackage

// ===== sv/mahony_ahrs_imu_update.sv =====
// Top level of the gyro plus accelerometer attitude filter update.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     req_data  (gyro and accel sample)
//   rsp      out        rsp_valid / rsp_ready     rsp_data  (updated quaternion, Q2.30)
//   csr      in         csr_valid / csr_ready     csr_data  (half sample period, Q0.30)
//
// Most of the run time goes to the restoring divider, one quotient bit per cycle, used
// up to seven times (three accel components, four quaternion components), and to up
// to two 32-step roots; a zero accel vector skips the accel root and its divisions.
// Reset loads the unit quaternion and the 100 Hz half period. The next item is taken
// while the previous result waits in the output register; a stalled result holds the
// sequencer at its final step.
module mahony_ahrs_imu_update (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  mahu_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output mahu_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [mahu_pkg::HSP_W-1:0]  csr_data
);
   import mahu_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   mahu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   mahu_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );
endmodule

// ===== sv/mahu_isqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
module mahu_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mahu_pkg::RAD_W-1:0]     radicand,
   output logic                           busy,
   output logic [mahu_pkg::ROOT_W-1:0]    root
);
   import mahu_pkg::*;

   logic               busy_ff, busy_in;
   logic [SQRT_CW-1:0] cnt_ff, cnt_in;
   logic [RAD_W-1:0]   rem_ff, rem_in;
   logic [RAD_W-1:0]   res_ff, res_in;
   logic [RAD_W-1:0]   bit_ff, bit_in;
   logic [RAD_W-1:0]   trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = RAD_W'(1) << (RAD_W - 2);
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SQRT_CW'(ROOT_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[ROOT_W-1:0];
endmodule

// ===== sv/mahu_div.sv =====
// Restoring divider for scaled, rounded signed quotients, one bit per cycle.
module mahu_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [mahu_pkg::DATA_W-1:0]         mag,
   input  logic                                neg,
   input  logic                                renorm,
   input  logic [mahu_pkg::ROOT_W-1:0]         divisor,
   output logic                                busy,
   output logic signed [mahu_pkg::DIV_RW-1:0]  quot
);
   import mahu_pkg::*;

   logic              busy_ff, busy_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_NW-1:0] dvd_ff, dvd_in;
   logic [ROOT_W-1:0] rem_ff, rem_in;
   logic              neg_ff, neg_in;
   logic [ROOT_W:0]   rem_sh;
   logic              ge;
   logic [DIV_NW:0]   q_inc;
   logic signed [DIV_RW-1:0] half;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DIV_NW-1]};
      ge      = rem_sh >= {1'b0, divisor};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         neg_in  = neg;
         dvd_in  = renorm ? (DIV_NW'(mag) << RENORM_SHIFT) : (DIV_NW'(mag) << ACCEL_SHIFT);
      end else if (busy_ff) begin
         rem_in = ge ? ROOT_W'(rem_sh - {1'b0, divisor}) : rem_sh[ROOT_W-1:0];
         dvd_in = {dvd_ff[DIV_NW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(DIV_NW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      q_inc = {1'b0, dvd_ff} + 1'b1;
      half  = $signed(q_inc >> 1);
      quot  = neg_ff ? -half : half;
   end

   assign busy = busy_ff;
endmodule

// ===== sv/mahu_ctrl.sv =====
// Sequencer for the filter update: multiply-accumulate program, root and division steps.
module mahu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mahu_pkg::cmd_type cmd,
   input  mahu_pkg::sts_type sts
);
   import mahu_pkg::*;

   state_type       state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            phase_ff, phase_in;
   logic [1:0]      idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_free;
   logic [1:0]      idx_last;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign idx_last = phase_ff ? 2'd3 : 2'd2;

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL;
               pc_in    = '0;
               phase_in = 1'b0;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (pc_ff == PC_ACCEL_END) begin
               if (sts.acc_zero) begin
                  state_in = ST_MUL;
                  pc_in    = PC_INT_START;
                  phase_in = 1'b1;
               end else begin
                  state_in = ST_SQRT;
               end
            end else if (pc_ff == PC_LAST) begin
               state_in = ST_SQRT;
            end else begin
               state_in = ST_MUL;
               pc_in    = pc_ff + 1'b1;
            end
         end
         ST_SQRT: begin
            if (!sts.sqrt_busy) begin
               idx_in = '0;
               if (phase_ff && sts.root_zero) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (!sts.div_busy) begin
               if (idx_ff == idx_last) begin
                  if (phase_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_MUL;
                     pc_in    = PC_FB_START;
                     phase_in = 1'b1;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.uop       = mahu_uop(pc_ff);
      cmd.renorm    = phase_ff;
      cmd.div_idx   = idx_ff;
      cmd.start_idx = idx_ff + 1'b1;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
         end
         ST_ACC: begin
            cmd.acc_en     = 1'b1;
            cmd.sqrt_start = (pc_ff == PC_ACCEL_END && !sts.acc_zero) || (pc_ff == PC_LAST);
         end
         ST_SQRT: begin
            cmd.start_idx = '0;
            if (!sts.sqrt_busy) begin
               if (phase_ff && sts.root_zero) begin
                  cmd.zero_state = 1'b1;
               end else begin
                  cmd.div_start = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (!sts.div_busy) begin
               cmd.div_write = 1'b1;
               cmd.div_start = idx_ff != idx_last;
            end
         end
         ST_DONE: begin
            cmd.rsp_load = rsp_free;
         end
         default: begin
            cmd.load = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         phase_ff     <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== sv/mahu_dp.sv =====
// Datapath: orientation state, working registers, shared multiplier, root and divider units.
module mahu_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  mahu_pkg::cmd_type         cmd,
   output mahu_pkg::sts_type         sts,
   input  mahu_pkg::req_type         req_data,
   input  logic                      csr_write,
   input  logic [mahu_pkg::HSP_W-1:0] csr_data,
   output mahu_pkg::rsp_type         rsp_data
);
   import mahu_pkg::*;

   logic [HSP_W-1:0]             hsp_ff;
   logic signed [QUAT_WIDTH-1:0] st_ff [4];
   logic signed [DATA_W-1:0]     a_ff [3];
   logic signed [OPND_W-1:0]     g_ff [3];
   logic signed [DATA_W-1:0]     v_ff [3];
   logic signed [DATA_W-1:0]     h_ff [3];
   logic signed [DATA_W-1:0]     n_ff [4];
   logic signed [PROD_W-1:0]     p_ff;
   logic signed [ACC_W-1:0]      acc_ff;
   rsp_type                      rsp_ff;

   logic signed [DATA_W-1:0]     q_w [4];
   logic signed [OPND_W-1:0]     opa, opb;
   logic signed [PROD_W-1:0]     p_in;
   logic signed [PROD_W-1:0]     term_w;
   logic signed [ACC_W-1:0]      acc_in;
   logic signed [DATA_W-1:0]     e32;
   logic signed [DATA_W:0]       e_shr;
   logic [RAD_W-1:0]             radicand;
   logic                         sqrt_busy;
   logic [ROOT_W-1:0]            root;
   logic signed [DATA_W-1:0]     div_src;
   logic [DATA_W-1:0]            div_mag;
   logic                         div_busy;
   logic signed [DIV_RW-1:0]     quot;

   localparam logic signed [OPND_W-1:0] ONE_Q30  = OPND_W'(1) <<< 30;
   localparam logic signed [OPND_W-1:0] HALF_Q30 = OPND_W'(1) <<< 29;
   localparam logic signed [PROD_W-1:0] RND24    = PROD_W'(1) <<< 23;
   localparam logic signed [PROD_W-1:0] RND30    = PROD_W'(1) <<< 29;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q_w[i] = to_q30(st_ff[i]);
      end
   end

   always_comb begin
      case (cmd.uop.a)
         OPD_Q0:   opa = OPND_W'(q_w[0]);
         OPD_Q1:   opa = OPND_W'(q_w[1]);
         OPD_Q2:   opa = OPND_W'(q_w[2]);
         OPD_Q3:   opa = OPND_W'(q_w[3]);
         OPD_A0:   opa = OPND_W'(a_ff[0]);
         OPD_A1:   opa = OPND_W'(a_ff[1]);
         OPD_A2:   opa = OPND_W'(a_ff[2]);
         OPD_G0:   opa = g_ff[0];
         OPD_G1:   opa = g_ff[1];
         OPD_G2:   opa = g_ff[2];
         OPD_N0:   opa = OPND_W'(n_ff[0]);
         OPD_N1:   opa = OPND_W'(n_ff[1]);
         OPD_N2:   opa = OPND_W'(n_ff[2]);
         OPD_N3:   opa = OPND_W'(n_ff[3]);
         OPD_ONE:  opa = ONE_Q30;
         default:  opa = '0;
      endcase
   end

   always_comb begin
      case (cmd.uop.b)
         OPD_Q0:   opb = OPND_W'(q_w[0]);
         OPD_Q1:   opb = OPND_W'(q_w[1]);
         OPD_Q2:   opb = OPND_W'(q_w[2]);
         OPD_Q3:   opb = OPND_W'(q_w[3]);
         OPD_A0:   opb = OPND_W'(a_ff[0]);
         OPD_A1:   opb = OPND_W'(a_ff[1]);
         OPD_A2:   opb = OPND_W'(a_ff[2]);
         OPD_V0:   opb = OPND_W'(v_ff[0]);
         OPD_V1:   opb = OPND_W'(v_ff[1]);
         OPD_V2:   opb = OPND_W'(v_ff[2]);
         OPD_H0:   opb = OPND_W'(h_ff[0]);
         OPD_H1:   opb = OPND_W'(h_ff[1]);
         OPD_H2:   opb = OPND_W'(h_ff[2]);
         OPD_N0:   opb = OPND_W'(n_ff[0]);
         OPD_N1:   opb = OPND_W'(n_ff[1]);
         OPD_N2:   opb = OPND_W'(n_ff[2]);
         OPD_N3:   opb = OPND_W'(n_ff[3]);
         OPD_ONE:  opb = ONE_Q30;
         OPD_HALF: opb = HALF_Q30;
         OPD_HSP:  opb = $signed({{(OPND_W-HSP_W){1'b0}}, hsp_ff});
         default:  opb = '0;
      endcase
   end

   assign p_in = opa * opb;

   always_comb begin
      case (cmd.uop.shift)
         SHF_NONE:   term_w = p_ff;
         SHF_FLOOR2: term_w = p_ff >>> 2;
         SHF_RND24:  term_w = (p_ff + RND24) >>> 24;
         SHF_RND30:  term_w = (p_ff + RND30) >>> 30;
         default:    term_w = p_ff;
      endcase
      if (cmd.uop.sub) begin
         acc_in = (cmd.uop.clr ? '0 : acc_ff) - ACC_W'(term_w);
      end else begin
         acc_in = (cmd.uop.clr ? '0 : acc_ff) + ACC_W'(term_w);
      end
      e32   = sat_acc32(acc_in);
      e_shr = ((DATA_W+1)'(e32) + (DATA_W+1)'(16)) >>> 5;
   end

   assign radicand = cmd.renorm ? RAD_W'(acc_in) : (RAD_W'(acc_in) << 30);

   always_comb begin
      div_src = cmd.renorm ? n_ff[cmd.start_idx] : a_ff[cmd.start_idx[1:0] == 2'd3 ? 2'd2
                                                               : cmd.start_idx];
      div_mag = div_src[DATA_W-1] ? DATA_W'(-div_src) : DATA_W'(div_src);
   end

   mahu_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (radicand),
      .busy     (sqrt_busy),
      .root     (root)
   );

   mahu_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .mag     (div_mag),
      .neg     (div_src[DATA_W-1]),
      .renorm  (cmd.renorm),
      .divisor (root),
      .busy    (div_busy),
      .quot    (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hsp_ff   <= HSP_RESET;
         st_ff[0] <= QUAT_WIDTH'(1) <<< QF;
         st_ff[1] <= '0;
         st_ff[2] <= '0;
         st_ff[3] <= '0;
      end else begin
         if (csr_write) begin
            hsp_ff <= csr_data;
         end
         if (cmd.zero_state) begin
            for (int i = 0; i < 4; i++) begin
               st_ff[i] <= '0;
            end
         end else if (cmd.div_write && cmd.renorm) begin
            st_ff[cmd.div_idx] <= sat_divq(quot);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         g_ff[0] <= OPND_W'(req_data.gyro_x);
         g_ff[1] <= OPND_W'(req_data.gyro_y);
         g_ff[2] <= OPND_W'(req_data.gyro_z);
         a_ff[0] <= DATA_W'(req_data.accel_x);
         a_ff[1] <= DATA_W'(req_data.accel_y);
         a_ff[2] <= DATA_W'(req_data.accel_z);
      end
      if (cmd.div_write && !cmd.renorm && cmd.div_idx != 2'd3) begin
         a_ff[cmd.div_idx] <= sat_div32(quot);
      end
      if (cmd.mul_en) begin
         p_ff <= p_in;
      end
      if (cmd.acc_en) begin
         acc_ff <= acc_in;
         case (cmd.uop.dest)
            DST_V0:  v_ff[0] <= e32;
            DST_V1:  v_ff[1] <= e32;
            DST_V2:  v_ff[2] <= e32;
            DST_G0:  g_ff[0] <= g_ff[0] + OPND_W'(e_shr);
            DST_G1:  g_ff[1] <= g_ff[1] + OPND_W'(e_shr);
            DST_G2:  g_ff[2] <= g_ff[2] + OPND_W'(e_shr);
            DST_H0:  h_ff[0] <= e32;
            DST_H1:  h_ff[1] <= e32;
            DST_H2:  h_ff[2] <= e32;
            DST_N0:  n_ff[0] <= e32;
            DST_N1:  n_ff[1] <= e32;
            DST_N2:  n_ff[2] <= e32;
            DST_N3:  n_ff[3] <= e32;
            default: begin
            end
         endcase
      end
      if (cmd.rsp_load) begin
         rsp_ff.quat_w <= q_w[0];
         rsp_ff.quat_x <= q_w[1];
         rsp_ff.quat_y <= q_w[2];
         rsp_ff.quat_z <= q_w[3];
      end
   end

   assign sts.acc_zero  = acc_in == '0;
   assign sts.sqrt_busy = sqrt_busy;
   assign sts.root_zero = root == '0;
   assign sts.div_busy  = div_busy;
   assign rsp_data      = rsp_ff;
endmodule

// ===== tb/testbench.sv =====
// Randomized and directed regression of the attitude filter update block against a bit-true predictor.
module testbench;
   import mahu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [HSP_W-1:0] csr_data = '0;

   longint      orient [4];
   longint      period;
   rsp_type     quat_queue [$];
   int          errors = 0;
   int          sent = 0;
   int          got = 0;
   int          idle_cycles = 0;

   mahony_ahrs_imu_update u_top (.*);

   always #1 clock = ~clock;

   function automatic longint rnd_sh(longint x, int k);
      if (k == 0) return x;
      return (x + (longint'(1) << (k - 1))) >>> k;
   endfunction

   function automatic longint clamp(longint x, int w);
      longint hi;
      hi = (longint'(1) << (w - 1)) - 1;
      return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
   endfunction

   function automatic longint mul30(longint a, longint b);
      return rnd_sh(a * b, 30);
   endfunction

   function automatic longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint quot_round(longint num, int s, longint unsigned d);
      longint unsigned mag, q, r;
      longint res;
      mag = num < 0 ? -num : num;
      q = mag / d;
      r = mag % d;
      for (int i = 0; i < s + 1; i++) begin
         if (q >= (64'd1 << 61)) begin
            q = (64'd1 << 62) - 1;
            break;
         end
         q <<= 1;
         r <<= 1;
         if (r >= d) begin
            r -= d;
            q |= 1;
         end
      end
      res = longint'((q + 1) >> 1);
      return num < 0 ? -res : res;
   endfunction

   function automatic longint as_q30(longint v);
      return clamp(rnd_sh(v, QF - 30), 32);
   endfunction

   function automatic rsp_type predict_quat(req_type it);
      longint g[3], a[3], q[4], h[3], n[4], vx, vy, vz, ex, ey, ez;
      longint unsigned s, nrm;
      rsp_type r;
      g[0] = it.gyro_x; g[1] = it.gyro_y; g[2] = it.gyro_z;
      a[0] = it.accel_x; a[1] = it.accel_y; a[2] = it.accel_z;
      for (int i = 0; i < 4; i++) q[i] = as_q30(orient[i]);
      s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      if (s != 0) begin
         nrm = root(s << 30);
         for (int i = 0; i < 3; i++) a[i] = clamp(quot_round(a[i], 45, nrm), 32);
         vx = clamp(mul30(q[1], q[3]) - mul30(q[0], q[2]), 32);
         vy = clamp(mul30(q[0], q[1]) + mul30(q[2], q[3]), 32);
         vz = clamp(mul30(q[0], q[0]) - (longint'(1) << 29) + mul30(q[3], q[3]), 32);
         ex = clamp(mul30(a[1], vz) - mul30(a[2], vy), 32);
         ey = clamp(mul30(a[2], vx) - mul30(a[0], vz), 32);
         ez = clamp(mul30(a[0], vy) - mul30(a[1], vx), 32);
         g[0] += rnd_sh(ex, 5);
         g[1] += rnd_sh(ey, 5);
         g[2] += rnd_sh(ez, 5);
      end
      for (int i = 0; i < 3; i++) h[i] = clamp(rnd_sh(g[i] * period, 24), 32);
      n[0] = clamp(q[0] - mul30(q[1], h[0]) - mul30(q[2], h[1]) - mul30(q[3], h[2]), 32);
      n[1] = clamp(q[1] + mul30(q[0], h[0]) + mul30(q[2], h[2]) - mul30(q[3], h[1]), 32);
      n[2] = clamp(q[2] + mul30(q[0], h[1]) - mul30(q[1], h[2]) + mul30(q[3], h[0]), 32);
      n[3] = clamp(q[3] + mul30(q[0], h[2]) + mul30(q[1], h[1]) - mul30(q[2], h[0]), 32);
      s = 0;
      for (int i = 0; i < 4; i++) s += longint'(longint'(n[i] * n[i]) >>> 2);
      nrm = root(s);
      for (int i = 0; i < 4; i++)
         orient[i] = (nrm == 0) ? 0 : clamp(quot_round(n[i], QF - 1, nrm), QUAT_WIDTH);
      r.quat_w = 32'(as_q30(orient[0]));
      r.quat_x = 32'(as_q30(orient[1]));
      r.quat_y = 32'(as_q30(orient[2]));
      r.quat_z = 32'(as_q30(orient[3]));
      return r;
   endfunction

   task automatic send_sample(req_type it);
      repeat ($urandom_range(0, 6)) @(negedge clock);
      req_data = it;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      quat_queue.push_back(predict_quat(it));
      sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain;
      while (quat_queue.size() != 0) @(negedge clock);
      repeat (700) @(negedge clock);
   endtask

   task automatic write_period(logic [31:0] value);
      drain();
      csr_data <= value[HSP_W-1:0];
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      period = value[HSP_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type rand_sample(int mode);
      req_type it;
      it.gyro_x = $urandom; it.gyro_y = $urandom; it.gyro_z = $urandom;
      it.accel_x = 16'($urandom); it.accel_y = 16'($urandom); it.accel_z = 16'($urandom);
      if (mode != 0) begin
         it.gyro_x = $signed(it.gyro_x) >>> $urandom_range(4, 31);
         it.gyro_y = $signed(it.gyro_y) >>> $urandom_range(4, 31);
         it.gyro_z = $signed(it.gyro_z) >>> $urandom_range(4, 31);
      end
      if ($urandom_range(0, 15) == 0) begin
         it.accel_x = '0; it.accel_y = '0; it.accel_z = '0;
      end
      return it;
   endfunction

   function automatic req_type sample(longint gx, longint gy, longint gz,
                                      int ax, int ay, int az);
      req_type it;
      it.gyro_x = 32'(gx); it.gyro_y = 32'(gy); it.gyro_z = 32'(gz);
      it.accel_x = 16'(ax); it.accel_y = 16'(ay); it.accel_z = 16'(az);
      return it;
   endfunction

   task automatic test_directed;
      send_sample(sample(0, 0, 0, 0, 0, 0));
      send_sample(sample(0, 0, 0, 0, 0, 16384));
      send_sample(sample(16777216, 0, 0, 0, 0, 0));
      send_sample(sample(0, -16777216, 8388608, 100, -200, 16384));
      send_sample(sample(0, 0, 0, 32767, 32767, 32767));
      send_sample(sample(0, 0, 0, -32768, -32768, -32768));
      send_sample(sample(0, 0, 0, -32768, 0, 0));
      send_sample(sample(0, 0, 0, 1, 0, 0));
      send_sample(sample(2147483647, 2147483647, 2147483647, 0, 1, 0));
      send_sample(sample(-2147483648, -2147483648, -2147483648, 0, 0, -1));
      send_sample(sample(2147483647, -2147483648, 0, 5, -7, 3));
   endtask

   task automatic test_period_extremes;
      write_period(32'h3FFF_FFFF);
      send_sample(sample(2147483647, -2147483648, 2147483647, 1, 2, 3));
      send_sample(sample(-2147483648, 2147483647, 1, 0, 0, 0));
      write_period(32'hFFFF_FFFF);
      send_sample(sample(16777216, 16777216, -16777216, 0, 0, 9000));
      write_period(0);
      send_sample(sample(2147483647, 2147483647, -2147483648, -1, 0, 0));
      send_sample(sample(123456, -654321, 0, 0, 0, 0));
      write_period(32'hC000_0001);
      send_sample(sample(-16777216, 0, 0, 300, 0, -300));
   endtask

   task automatic test_random(int count, int mode);
      for (int i = 0; i < count; i++) send_sample(rand_sample(mode));
   endtask

   // random ready stalls, sometimes none
   initial begin
      int unsigned stall;
      @(negedge clock);
      forever begin
         stall = $urandom_range(0, 6);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_type e;
         got++;
         if (quat_queue.size() == 0) begin
            $error("quaternion with no expectation: %h", rsp_data);
            errors++;
         end else begin
            e = quat_queue.pop_front();
            if (rsp_data.quat_w !== e.quat_w) begin
               $error("quat_w expected %h got %h", e.quat_w, rsp_data.quat_w); errors++;
            end
            if (rsp_data.quat_x !== e.quat_x) begin
               $error("quat_x expected %h got %h", e.quat_x, rsp_data.quat_x); errors++;
            end
            if (rsp_data.quat_y !== e.quat_y) begin
               $error("quat_y expected %h got %h", e.quat_y, rsp_data.quat_y); errors++;
            end
            if (rsp_data.quat_z !== e.quat_z) begin
               $error("quat_z expected %h got %h", e.quat_z, rsp_data.quat_z); errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || (quat_queue.size() == 0 && !req_valid && !csr_valid))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      orient[0] = longint'(1) << QF;
      orient[1] = 0; orient[2] = 0; orient[3] = 0;
      period = HSP_RESET;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_period_extremes();
      write_period(32'(HSP_RESET));
      test_random(250, 1);
      write_period(32'd53687091);
      test_random(200, 1);
      write_period(32'd268435);
      test_random(150, 0);
      test_random(80, 1);
      drain();
      $display("Sent %0d samples, checked %0d quaternions over six period settings.",
               sent, got);
      if (errors == 0 && quat_queue.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
